FILE: rtl/omq_pkg.sv
`default_nettype none
package omq_pkg;

  localparam int DEVICE_COUNT = 64;
  localparam int DEV_W        = 6;
  localparam int DEV_IDX_W    = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
  localparam int CNT_W        = $clog2(DEVICE_COUNT + 1);
  localparam int MIDX_W       = 4;
  localparam int MASK_W       = 16;
  localparam int MODE_W       = 3;

  localparam logic [MASK_W-1:0] MASK_TOP = 16'h8000;

  typedef enum logic [MODE_W-1:0] {
    MODE_RAISE  = 3'd0,
    MODE_LOWER  = 3'd1,
    MODE_POLL   = 3'd2,
    MODE_MASK   = 3'd3,
    MODE_ACK    = 3'd4,
    MODE_ENABLE = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOWER,
    ST_POLL,
    ST_MOVE,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [DEV_W-1:0]  dev;
    logic [MIDX_W-1:0] midx;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic pop;
    logic push;
  } chain_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/omq_cell.sv
`default_nettype none
module omq_cell (
  input  wire                  clk_i,
  input  omq_pkg::cell_ctrl_t  ctrl_i,
  input  omq_pkg::entry_t      next_entry_i,
  input  omq_pkg::entry_t      load_entry_i,
  output omq_pkg::entry_t      entry_o
);

  omq_pkg::entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      entry_q <= load_entry_i;
    end else if (ctrl_i.shift) begin
      entry_q <= next_entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

FILE: rtl/omq_chain.sv
`default_nettype none
module omq_chain (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  omq_pkg::chain_cmd_t            cmd_i,
  input  omq_pkg::entry_t                push_entry_i,
  output omq_pkg::entry_t                head_o,
  output logic [omq_pkg::CNT_W-1:0]      count_o
);

  localparam int N = omq_pkg::DEVICE_COUNT;
  localparam int CW = omq_pkg::CNT_W;

  logic [CW-1:0] cnt_q, cnt_d, pos;
  omq_pkg::entry_t cell_out [N];

  // a pop shifts every cell toward the head, so the tail slot moves down one
  assign pos = cmd_i.pop ? (cnt_q - CW'(1)) : cnt_q;

  for (genvar i = 0; i < N; i++) begin : g_cell
    omq_pkg::cell_ctrl_t ctrl;
    omq_pkg::entry_t     nxt;

    assign ctrl.shift = cmd_i.pop;
    assign ctrl.load  = cmd_i.push && (pos == CW'(i));

    if (i == N - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = cell_out[i+1];
    end

    omq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .next_entry_i (nxt),
      .load_entry_i (push_entry_i),
      .entry_o      (cell_out[i])
    );
  end

  assign cnt_d = cnt_q + CW'(cmd_i.push) - CW'(cmd_i.pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign head_o  = cell_out[0];
  assign count_o = cnt_q;

endmodule
`default_nettype wire

FILE: rtl/masked_interrupt_order_queue_top.sv
`default_nettype none
// Interrupt order queue with a pending list and a masked list, each a chain of
// cells that moves one position per cycle while popped. Raise, acknowledge, set
// enable, unused modes, lower of an idle device and poll while disabled answer
// straight from the idle state. Lower of a queued device rotates both chains
// once past their head in ST_LOWER, dropping the device, and then reports from
// ST_RESP. Poll moves each masked head to the masked list until it meets an
// unmasked head or an empty list, then reports. Set mask appends every masked
// entry to the pending list, then reports. One transaction is in the block at a
// time. A result register decouples the output handshake from the next
// transaction.
module masked_interrupt_order_queue_top (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire  [omq_pkg::MODE_W-1:0]      mode_i,
  input  wire  [omq_pkg::DEV_W-1:0]       device_i,
  input  wire  [omq_pkg::MIDX_W-1:0]      mask_bit_i,
  input  wire  [omq_pkg::MASK_W-1:0]      mask_value_i,
  input  wire                             enable_value_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic                            found_o,
  output logic [omq_pkg::DEV_W-1:0]       device_out_o
);

  localparam int N  = omq_pkg::DEVICE_COUNT;
  localparam int CW = omq_pkg::CNT_W;

  omq_pkg::state_e state_q, state_d;

  logic [omq_pkg::MASK_W-1:0] mask_q, mask_d;
  logic                       en_q, en_d;
  logic [N-1:0]               queued_q, queued_d;
  logic [omq_pkg::DEV_W-1:0]  dev_q, dev_d;
  logic [CW-1:0]              rem_p_q, rem_p_d, rem_m_q, rem_m_d;
  logic                       res_found_q, res_found_d;
  logic [omq_pkg::DEV_W-1:0]  res_dev_q, res_dev_d;
  logic                       out_valid_q, out_valid_d;
  logic                       found_q, found_d;
  logic [omq_pkg::DEV_W-1:0]  dev_out_q, dev_out_d;

  omq_pkg::chain_cmd_t pcmd, mcmd;
  omq_pkg::entry_t     p_push_entry, m_push_entry, p_head, m_head;
  logic [CW-1:0]       p_count, m_count;

  logic                          out_free;
  logic                          dev_ok;
  logic [omq_pkg::DEV_IDX_W-1:0] didx;
  logic                          head_masked;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == omq_pkg::ST_IDLE) && out_free;
  assign dev_ok      = ({1'b0, device_i} < (omq_pkg::DEV_W + 1)'(N));
  assign didx        = device_i[omq_pkg::DEV_IDX_W-1:0];
  assign head_masked = |((omq_pkg::MASK_TOP >> p_head.midx) & mask_q);

  omq_chain u_pending (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (pcmd),
    .push_entry_i (p_push_entry),
    .head_o       (p_head),
    .count_o      (p_count)
  );

  omq_chain u_masked (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (mcmd),
    .push_entry_i (m_push_entry),
    .head_o       (m_head),
    .count_o      (m_count)
  );

  always_comb begin
    state_d      = state_q;
    mask_d       = mask_q;
    en_d         = en_q;
    queued_d     = queued_q;
    dev_d        = dev_q;
    rem_p_d      = rem_p_q;
    rem_m_d      = rem_m_q;
    res_found_d  = res_found_q;
    res_dev_d    = res_dev_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    found_d      = found_q;
    dev_out_d    = dev_out_q;
    pcmd         = '0;
    mcmd         = '0;
    p_push_entry = '{dev: device_i, midx: mask_bit_i};
    m_push_entry = p_head;

    unique case (state_q)
      omq_pkg::ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          out_valid_d = 1'b1;
          found_d     = 1'b0;
          dev_out_d   = '0;
          unique case (omq_pkg::mode_e'(mode_i))
            omq_pkg::MODE_RAISE: begin
              if (dev_ok && !queued_q[didx]) begin
                pcmd.push      = 1'b1;
                queued_d[didx] = 1'b1;
              end
            end
            omq_pkg::MODE_LOWER: begin
              if (dev_ok && queued_q[didx]) begin
                queued_d[didx] = 1'b0;
                dev_d          = device_i;
                rem_p_d        = p_count;
                rem_m_d        = m_count;
                out_valid_d    = 1'b0;
                state_d        = omq_pkg::ST_LOWER;
              end
            end
            omq_pkg::MODE_POLL: begin
              if (en_q) begin
                out_valid_d = 1'b0;
                state_d     = omq_pkg::ST_POLL;
              end
            end
            omq_pkg::MODE_MASK: begin
              mask_d      = mask_value_i;
              out_valid_d = 1'b0;
              state_d     = omq_pkg::ST_MOVE;
            end
            omq_pkg::MODE_ACK: begin
              if (p_count != '0) begin
                found_d   = 1'b1;
                dev_out_d = p_head.dev;
              end
            end
            omq_pkg::MODE_ENABLE: begin
              en_d = enable_value_i;
            end
            default: begin
            end
          endcase
        end
      end
      omq_pkg::ST_LOWER: begin
        // rotate both lists once, dropping the lowered device
        p_push_entry = p_head;
        m_push_entry = m_head;
        if (rem_p_q != '0) begin
          pcmd.pop  = 1'b1;
          pcmd.push = (p_head.dev != dev_q);
          rem_p_d   = rem_p_q - CW'(1);
        end
        if (rem_m_q != '0) begin
          mcmd.pop  = 1'b1;
          mcmd.push = (m_head.dev != dev_q);
          rem_m_d   = rem_m_q - CW'(1);
        end
        if (rem_p_q == '0 && rem_m_q == '0) begin
          res_found_d = 1'b0;
          res_dev_d   = '0;
          state_d     = omq_pkg::ST_RESP;
        end
      end
      omq_pkg::ST_POLL: begin
        if (p_count == '0) begin
          res_found_d = 1'b0;
          res_dev_d   = '0;
          state_d     = omq_pkg::ST_RESP;
        end else if (head_masked) begin
          pcmd.pop     = 1'b1;
          mcmd.push    = 1'b1;
          m_push_entry = p_head;
        end else begin
          res_found_d = 1'b1;
          res_dev_d   = p_head.dev;
          en_d        = 1'b0;
          state_d     = omq_pkg::ST_RESP;
        end
      end
      omq_pkg::ST_MOVE: begin
        if (m_count != '0) begin
          mcmd.pop     = 1'b1;
          pcmd.push    = 1'b1;
          p_push_entry = m_head;
        end else begin
          res_found_d = 1'b0;
          res_dev_d   = '0;
          state_d     = omq_pkg::ST_RESP;
        end
      end
      omq_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          found_d     = res_found_q;
          dev_out_d   = res_dev_q;
          state_d     = omq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = omq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= omq_pkg::ST_IDLE;
      mask_q      <= '0;
      en_q        <= 1'b0;
      queued_q    <= '0;
      rem_p_q     <= '0;
      rem_m_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mask_q      <= mask_d;
      en_q        <= en_d;
      queued_q    <= queued_d;
      rem_p_q     <= rem_p_d;
      rem_m_q     <= rem_m_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dev_q       <= dev_d;
    res_found_q <= res_found_d;
    res_dev_q   <= res_dev_d;
    found_q     <= found_d;
    dev_out_q   <= dev_out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign device_out_o = dev_out_q;

endmodule
`default_nettype wire
